// File: sv/kmwo_pkg.sv
package kmwo_pkg;

  // block sizing
  localparam int unsigned NumKeys    = 15;
  localparam int unsigned SampleRate = 48000;
  localparam int unsigned SineDepth  = 256;
  localparam int unsigned PhaseBits  = 32;

  // field widths
  localparam int unsigned IndexW  = 32;
  localparam int unsigned KeysW   = 15;
  localparam int unsigned SampleW = 16;
  localparam int unsigned KeyIdxW = (NumKeys > 1) ? $clog2(NumKeys) : 1;
  localparam int unsigned FracW   = 32;
  localparam int unsigned SineAw  = $clog2(SineDepth);
  localparam int unsigned SineW   = 15;

  // fixed point constants
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;
  localparam logic [63:0] SeriesDiv [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
  localparam logic [SampleW-1:0] FullScale = 16'd32767;

  // key pitches in Hz, unsigned Q16
  localparam int unsigned KeyFreqQ16 [32] = '{
    28835840, 30550508, 32367136, 34291786, 36330882, 38491228,
    40780036, 43204943, 45774043, 48495909, 51379626, 54434817,
    57671680, 61101017, 64734272, 68583572, 72661764, 76982457,
    81560072, 86409886, 91548085, 96991818, 102759252, 108869635,
    115343360, 122202033, 129468544, 137167144, 145323527, 153964914,
    163120144, 172819773
  };

  typedef enum logic [1:0] {
    WaveSine   = 2'd0,
    WaveSquare = 2'd1,
    WaveSaw    = 2'd2,
    WaveTri    = 2'd3
  } wave_e;

  typedef logic [NumKeys-1:0][PhaseBits-1:0] word_tab_t;
  typedef logic [SineDepth:0][SineW-1:0]     sine_tab_t;

  // tuning word per key, rounded halves up
  function automatic word_tab_t build_words();
    word_tab_t   tab;
    logic [63:0] num;
    for (int k = 0; k < NumKeys; k++) begin
      num    = 64'(KeyFreqQ16[k]) << (PhaseBits - 16);
      tab[k] = PhaseBits'((num + 64'(SampleRate / 2)) / SampleRate);
    end
    return tab;
  endfunction

  // one quarter-wave entry from a nested odd series in Q30
  function automatic logic [SineW-1:0] sine_entry(int unsigned i);
    logic [63:0] ang;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sub;
    logic [63:0] v;
    ang = (HalfPiQ30 * 64'(i)) / SineDepth;
    x2  = (ang * ang) >> 30;
    t   = OneQ30;
    for (int n = 0; n < 5; n++) begin
      sub = ((x2 * t) >> 30) / SeriesDiv[n];
      t   = (sub < OneQ30) ? OneQ30 - sub : 64'd0;
    end
    v = ((((ang * t) >> 30) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SineW-1:0];
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int i = 0; i <= SineDepth; i++) begin
      tab[i] = sine_entry(i);
    end
    return tab;
  endfunction

  localparam word_tab_t TuneWords = build_words();
  localparam sine_tab_t SineTable = build_sine();

endpackage

// File: sv/kmwo_if.sv
// request channel: time index and held keys
interface kmwo_in_if;
  logic                           valid;
  logic                           ready;
  logic [kmwo_pkg::IndexW-1:0]    sample_index;
  logic [kmwo_pkg::KeysW-1:0]     keys_down;

  modport source (output valid, sample_index, keys_down, input ready);
  modport sink   (input valid, sample_index, keys_down, output ready);
endinterface

// result channel: one audio sample
interface kmwo_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kmwo_pkg::SampleW-1:0] sample_value;
  logic                                note_active;

  modport source (output valid, sample_value, note_active, input ready);
  modport sink   (input valid, sample_value, note_active, output ready);
endinterface

// File: sv/keyed_multi_waveform_oscillator.sv
// Keyed multi-waveform oscillator. Each request brings a sample index and a
// mask of held keys; the highest held key picks a tuning word for
// 440*2^(k/12) Hz, the phase is index times word, and the waveform register
// (sine, square, sawtooth, triangle) shapes it into a Q1.15 sample, or silence
// with note_active low when no key is held. The block takes one request per
// clock unless a stalled output backs up a full pipeline; key encode, tuning
// lookup, the 32x32 phase multiply, and the waveform shaper each own a
// register stage. Valid bits walk with the data, so a stalled output holds its
// sample while the earlier stages keep filling their empty slots. Change the
// waveform register only when no request is in flight.
module keyed_multi_waveform_oscillator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  kmwo_in_if.sink          in_i,
  kmwo_out_if.source       out_o
);

  kmwo_pkg::wave_e wave_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  logic [kmwo_pkg::KeyIdxW-1:0]   key_d, key_q;
  logic                           act_d, act1_q, act2_q, act3_q, act4_q;
  logic [kmwo_pkg::IndexW-1:0]    idx1_q, idx2_q;
  logic [kmwo_pkg::PhaseBits-1:0] word_d, word_q;
  logic [kmwo_pkg::PhaseBits-1:0] phase_d, phase_q;
  logic [kmwo_pkg::FracW-1:0]     frac;
  logic signed [kmwo_pkg::SampleW-1:0] shape;
  logic signed [kmwo_pkg::SampleW-1:0] sample_d, sample_q;

  // waveform register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= kmwo_pkg::WaveSine;
    end else if (cfg_we_i) begin
      wave_q <= kmwo_pkg::wave_e'(cfg_wdata_i);
    end
  end

  // per stage advance: a stage moves when empty or when the next one moves
  assign adv4       = !v4_q || out_o.ready;
  assign adv3       = !v3_q || adv4;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_i.valid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (adv4) begin
        v4_q <= v3_q;
      end
    end
  end

  // stage 1: highest held key
  always_comb begin
    key_d = '0;
    act_d = 1'b0;
    for (int k = 0; k < kmwo_pkg::NumKeys; k++) begin
      if (in_i.keys_down[k]) begin
        key_d = kmwo_pkg::KeyIdxW'(k);
        act_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_i.valid) begin
      key_q  <= key_d;
      act1_q <= act_d;
      idx1_q <= in_i.sample_index;
    end
  end

  // stage 2: tuning word lookup
  assign word_d = kmwo_pkg::TuneWords[key_q];

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      word_q <= word_d;
      act2_q <= act1_q;
      idx2_q <= idx1_q;
    end
  end

  // stage 3: phase multiply, kept modulo the phase width
  assign phase_d = kmwo_pkg::PhaseBits'(idx2_q * word_q);

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      phase_q <= phase_d;
      act3_q  <= act2_q;
    end
  end

  // normalize the phase to a 32-bit fraction of one period
  if (kmwo_pkg::PhaseBits >= kmwo_pkg::FracW) begin : g_frac_hi
    assign frac = phase_q[kmwo_pkg::PhaseBits-1 -: kmwo_pkg::FracW];
  end else begin : g_frac_lo
    assign frac = {phase_q, {(kmwo_pkg::FracW - kmwo_pkg::PhaseBits){1'b0}}};
  end

  // stage 4: waveform shaping into the output register
  kmwo_shape u_shape (
    .phase_i  (frac),
    .wave_i   (wave_q),
    .sample_o (shape)
  );

  assign sample_d = act3_q ? shape : '0;

  always_ff @(posedge clk_i) begin
    if (adv4 && v3_q) begin
      sample_q <= sample_d;
      act4_q   <= act3_q;
    end
  end

  assign out_o.valid        = v4_q;
  assign out_o.sample_value = sample_q;
  assign out_o.note_active  = act4_q;

endmodule

// File: sv/kmwo_shape.sv
// maps a phase fraction to one sample of the selected waveform
module kmwo_shape (
  input  logic [kmwo_pkg::FracW-1:0]          phase_i,
  input  kmwo_pkg::wave_e                     wave_i,
  output logic signed [kmwo_pkg::SampleW-1:0] sample_o
);

  localparam int unsigned PosW = kmwo_pkg::SineAw + 2;

  logic [PosW-1:0]                 pos;
  logic [1:0]                      quad;
  logic [kmwo_pkg::SineAw-1:0]     off;
  logic [kmwo_pkg::SineAw:0]       sine_idx;
  logic [kmwo_pkg::SineW-1:0]      sine_mag;
  logic signed [kmwo_pkg::SampleW-1:0] sine_val;
  logic signed [kmwo_pkg::SampleW-1:0] square_val;
  logic [48:0]                     saw_prod;
  logic signed [kmwo_pkg::SampleW:0] saw_val;
  logic [32:0]                     tri_off;
  logic [48:0]                     tri_prod;
  logic signed [kmwo_pkg::SampleW:0] tri_val;

  // quarter-wave lookup with mirror and sign
  always_comb begin
    pos      = phase_i[kmwo_pkg::FracW-1 -: PosW];
    quad     = pos[PosW-1 -: 2];
    off      = pos[kmwo_pkg::SineAw-1:0];
    sine_idx = quad[0] ? (kmwo_pkg::SineAw+1)'(kmwo_pkg::SineDepth) - {1'b0, off}
                       : {1'b0, off};
    sine_mag = kmwo_pkg::SineTable[sine_idx];
    sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
  end

  // square: high through the half period inclusive
  always_comb begin
    square_val = (phase_i <= 32'h8000_0000) ? $signed(kmwo_pkg::FullScale)
                                            : -$signed(kmwo_pkg::FullScale);
  end

  // sawtooth: round(p * 65534 / 2^32) - 32767, times 65534 as shift and subtract
  always_comb begin
    saw_prod = ({17'd0, phase_i} << 16) - ({17'd0, phase_i} << 1) + (49'd1 << 31);
    saw_val  = $signed({1'b0, saw_prod[47:32]}) - $signed(17'd32767);
  end

  // triangle: fold the phase into a triangular offset over [0, 2^31]
  always_comb begin
    if ({1'b0, phase_i} <= 33'h0_4000_0000) begin
      tri_off = {1'b0, phase_i} + 33'h0_4000_0000;
    end else if ({1'b0, phase_i} <= 33'h0_C000_0000) begin
      tri_off = 33'h0_C000_0000 - {1'b0, phase_i};
    end else begin
      tri_off = {1'b0, phase_i} - 33'h0_C000_0000;
    end
    tri_prod = ({16'd0, tri_off} << 16) - ({16'd0, tri_off} << 1) + (49'd1 << 30);
    tri_val  = $signed({1'b0, tri_prod[46:31]}) - $signed(17'd32767);
  end

  // waveform select
  always_comb begin
    case (wave_i)
      kmwo_pkg::WaveSine:   sample_o = sine_val;
      kmwo_pkg::WaveSquare: sample_o = square_val;
      kmwo_pkg::WaveSaw:    sample_o = saw_val[kmwo_pkg::SampleW-1:0];
      kmwo_pkg::WaveTri:    sample_o = tri_val[kmwo_pkg::SampleW-1:0];
      default:              sample_o = '0;
    endcase
  end

endmodule

// File: sv/kmwo_checker.sv
// port level checks on the oscillator result channel
module kmwo_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [kmwo_pkg::SampleW-1:0] sample_value_i,
  input logic                                note_active_i
);

  // a pending result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_value_i) && $stable(note_active_i))
    else $error("result changed while stalled");

  // silence when no key is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !note_active_i |-> sample_value_i == '0)
    else $error("sound without a held key");

  // samples stay within symmetric full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sample_value_i != 16'sh8000)
    else $error("sample beyond full scale");

endmodule

bind keyed_multi_waveform_oscillator kmwo_checker u_kmwo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .sample_value_i (out_o.sample_value),
  .note_active_i  (out_o.note_active)
);
